### rtl/egi_pkg.sv
// shared types and constants for the elevation grid interpolator
package egi_pkg;

    localparam int TILE_DIM   = 1201;
    localparam int FRAC_BITS  = 16;
    localparam int CELL_COUNT = TILE_DIM * TILE_DIM;
    localparam int DIM_W      = $clog2(TILE_DIM);
    localparam int POS_W      = FRAC_BITS + DIM_W;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int A_W        = FRAC_BITS + 1;
    localparam int H_W        = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // command handed from the front end to the back end
    typedef struct packed {
        logic              is_query;
        logic              wr_ok;
        logic [ADDR_W-1:0] addr;
        logic [H_W-1:0]    data;
        logic [A_W-1:0]    a;
        logic [A_W-1:0]    fy;
    } t_cmd;

endpackage

### rtl/egi_if.sv
// valid/ready channel interfaces for input items, results and configuration
interface egi_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [20:0] load_index;
    logic [15:0] raw_height;
    logic [15:0] lat_frac;
    logic [15:0] lon_frac;
    modport source (output valid, opcode, load_index, raw_height, lat_frac, lon_frac,
                    input ready);
    modport sink (input valid, opcode, load_index, raw_height, lat_frac, lon_frac,
                  output ready);
endinterface

interface egi_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] altitude;
    logic [2:0]         void_count;
    modport source (output valid, altitude, void_count, input ready);
    modport sink (input valid, altitude, void_count, output ready);
endinterface

interface egi_cfg_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

### rtl/egi_fifo.sv
// short command queue between front end and back end
module egi_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  egi_pkg::t_cmd         i_data,
    input  logic                  i_pop,
    output egi_pkg::t_cmd         o_data,
    output logic                  o_empty,
    output logic [egi_pkg::CNT_W-1:0] o_count
);
    import egi_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    t_cmd             r_buf [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_buf[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
endmodule

### rtl/egi_front.sv
// front end: accepts items, swaps load bytes, turns queries into grid address and weights
module egi_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    egi_in_if.sink                    i_in,
    input  logic [egi_pkg::CNT_W-1:0] i_fifo_count,
    output logic                      o_push,
    output egi_pkg::t_cmd             o_cmd
);
    import egi_pkg::*;

    localparam logic [POS_W-1:0] ONE_P  = POS_W'(1) << FRAC_BITS;
    localparam logic [POS_W-1:0] TOP_P  = POS_W'(TILE_DIM - 1) << FRAC_BITS;
    localparam logic [A_W-1:0]   ONE_A  = A_W'(1) << FRAC_BITS;

    logic              r_s1_v;
    logic              r_s1_op;
    logic              r_s1_ok;
    logic [ADDR_W-1:0] r_s1_idx;
    logic [H_W-1:0]    r_s1_data;
    logic [POS_W-1:0]  r_s1_xs;
    logic [POS_W-1:0]  r_s1_ys;
    logic              r_s2_v;
    t_cmd              r_s2_cmd;

    logic              accept;
    logic [POS_W-1:0]  lon_prod;
    logic [POS_W-1:0]  lat_prod;
    logic [POS_W-1:0]  n_xs;
    logic [POS_W-1:0]  n_ys;
    logic [DIM_W-1:0]  col;
    logic [DIM_W-1:0]  row;
    logic [A_W-1:0]    a;
    logic [A_W-1:0]    fy;
    t_cmd              n_cmd;

    // credit check: everything in flight must fit in the queue
    assign i_in.ready = (CNT_W'(i_fifo_count) + CNT_W'(r_s1_v) + CNT_W'(r_s2_v))
                        < CNT_W'(FIFO_DEPTH);
    assign accept = i_in.valid && i_in.ready;

    always_comb begin
        lon_prod = POS_W'(i_in.lon_frac) * POS_W'(TILE_DIM);
        lat_prod = POS_W'(i_in.lat_frac) * POS_W'(TILE_DIM);
        n_xs = (lon_prod < ONE_P) ? '0 : lon_prod - ONE_P;
        // row position below one clamps to one
        n_ys = (lat_prod + ONE_P > TOP_P) ? ONE_P : TOP_P - lat_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= accept;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_op   <= i_in.opcode;
        r_s1_ok   <= ({1'b0, i_in.load_index} < (ADDR_W + 1)'(CELL_COUNT));
        r_s1_idx  <= ADDR_W'(i_in.load_index);
        r_s1_data <= {i_in.raw_height[7:0], i_in.raw_height[15:8]};
        r_s1_xs   <= n_xs;
        r_s1_ys   <= n_ys;
        r_s2_cmd  <= n_cmd;
    end

    always_comb begin
        col = r_s1_xs[POS_W-1:FRAC_BITS];
        a   = {1'b0, r_s1_xs[FRAC_BITS-1:0]};
        if (col > DIM_W'(TILE_DIM - 2)) begin
            col = DIM_W'(TILE_DIM - 2);
            a   = ONE_A;
        end
        row = r_s1_ys[POS_W-1:FRAC_BITS];
        fy  = {1'b0, r_s1_ys[FRAC_BITS-1:0]};
        if (row > DIM_W'(TILE_DIM - 1)) begin
            row = DIM_W'(TILE_DIM - 1);
            fy  = '0;
        end
        n_cmd.is_query = (r_s1_op == OP_QUERY);
        n_cmd.wr_ok    = r_s1_ok;
        n_cmd.data     = r_s1_data;
        n_cmd.a        = a;
        n_cmd.fy       = fy;
        if (r_s1_op == OP_QUERY) begin
            n_cmd.addr = ADDR_W'(row * ADDR_W'(TILE_DIM)) + ADDR_W'(col);
        end else begin
            n_cmd.addr = r_s1_idx;
        end
    end

    assign o_push = r_s2_v;
    assign o_cmd  = r_s2_cmd;
endmodule

### rtl/egi_back.sv
// back end: tile memory, four neighbour reads, void handling and bilinear blend
module egi_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  egi_pkg::t_cmd         i_cmd,
    input  logic                  i_empty,
    output logic                  o_pop,
    input  logic signed [15:0]    i_marker,
    egi_out_if.source             o_out
);
    import egi_pkg::*;

    localparam int SUM_W = H_W + 2;
    localparam int T_W   = H_W + A_W + 2;
    localparam int ACC_W = T_W + A_W + 1;
    localparam logic [A_W-1:0] ONE_A = A_W'(1) << FRAC_BITS;
    localparam logic [15:0] RECIP3 = 16'd43691;

    logic [H_W-1:0]    r_mem [CELL_COUNT];
    logic [H_W-1:0]    r_rdata;
    logic [1:0]        r_step;
    logic              r_rd_v;
    logic [1:0]        r_rd_idx;
    logic [A_W-1:0]    r_rd_a;
    logic [A_W-1:0]    r_rd_fy;
    logic signed [H_W-1:0] r_h [4];

    logic              r_e0_v;
    logic [A_W-1:0]    r_e0_a;
    logic [A_W-1:0]    r_e0_fy;

    logic              r_e1_v;
    logic signed [H_W-1:0] r_e1_h [4];
    logic [3:0]        r_e1_isv;
    logic [2:0]        r_e1_voids;
    logic signed [SUM_W-1:0] r_e1_sum;
    logic [A_W-1:0]    r_e1_a;
    logic [A_W-1:0]    r_e1_fy;

    logic              r_e2_v;
    logic signed [H_W-1:0] r_e2_h [4];
    logic [3:0]        r_e2_isv;
    logic [2:0]        r_e2_voids;
    logic signed [H_W-1:0] r_e2_mean;
    logic [A_W-1:0]    r_e2_a;
    logic [A_W-1:0]    r_e2_fy;

    logic              r_e3_v;
    logic signed [T_W-1:0] r_e3_top;
    logic signed [T_W-1:0] r_e3_bot;
    logic [2:0]        r_e3_voids;
    logic signed [H_W-1:0] r_e3_mean;
    logic [A_W-1:0]    r_e3_fy;

    logic              r_e4_v;
    logic signed [ACC_W-1:0] r_e4_acc;
    logic [2:0]        r_e4_voids;
    logic signed [H_W-1:0] r_e4_mean;

    logic              r_o_valid;
    logic signed [H_W-1:0] r_o_alt;
    logic [2:0]        r_o_vc;

    logic              adv;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] maddr;
    logic [1:0]        n_step;
    logic [3:0]        isv;
    logic [2:0]        voids;
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-2:0]  mag;
    logic [SUM_W+15:0] prod3;
    logic [SUM_W-2:0]  quo;
    logic signed [H_W-1:0] mean;
    logic signed [H_W-1:0] hh [4];
    logic signed [A_W:0] wa;
    logic signed [A_W:0] wna;
    logic signed [A_W:0] wfy;
    logic signed [A_W:0] wnfy;
    logic signed [ACC_W-1:0] acc_adj;
    logic signed [ACC_W-1:0] blend;
    logic signed [H_W-1:0] n_alt;

    // whole back end stalls while a result waits at the output
    assign adv = !r_o_valid || o_out.ready;

    always_comb begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        o_pop  = 1'b0;
        n_step = r_step;
        maddr  = i_cmd.addr;
        if (adv && !i_empty) begin
            if (!i_cmd.is_query) begin
                mem_we = i_cmd.wr_ok;
                o_pop  = 1'b1;
            end else begin
                mem_re = 1'b1;
                case (r_step)
                    2'd0: maddr = i_cmd.addr;
                    2'd1: maddr = i_cmd.addr + ADDR_W'(1);
                    2'd2: maddr = i_cmd.addr - ADDR_W'(TILE_DIM);
                    default: maddr = i_cmd.addr - ADDR_W'(TILE_DIM) + ADDR_W'(1);
                endcase
                if (r_step == 2'd3) begin
                    o_pop  = 1'b1;
                    n_step = 2'd0;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[maddr] <= i_cmd.data;
        end
        if (mem_re) begin
            r_rdata <= r_mem[maddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= '0;
            r_rd_v    <= 1'b0;
            r_e0_v    <= 1'b0;
            r_e1_v    <= 1'b0;
            r_e2_v    <= 1'b0;
            r_e3_v    <= 1'b0;
            r_e4_v    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (adv) begin
                r_rd_v    <= mem_re;
                r_e0_v    <= r_rd_v && (r_rd_idx == 2'd3);
                r_e1_v    <= r_e0_v;
                r_e2_v    <= r_e1_v;
                r_e3_v    <= r_e2_v;
                r_e4_v    <= r_e3_v;
                r_o_valid <= r_e4_v;
            end
        end
    end

    // stage 0: void flags, count and sum of valid neighbours
    always_comb begin
        voids = '0;
        sum   = '0;
        for (int i = 0; i < 4; i++) begin
            isv[i] = (r_h[i] == i_marker);
            if (isv[i]) begin
                voids = voids + 3'd1;
            end else begin
                sum = sum + SUM_W'(r_h[i]);
            end
        end
    end

    // stage 1: mean truncated toward zero, divide by three via reciprocal
    always_comb begin
        mag   = (SUM_W-1)'(r_e1_sum[SUM_W-1] ? -r_e1_sum : r_e1_sum);
        prod3 = (SUM_W+16)'(mag) * (SUM_W+16)'(RECIP3);
        case (r_e1_voids)
            3'd0: quo = mag >> 2;
            3'd1: quo = (SUM_W-1)'(prod3 >> 17);
            3'd2: quo = mag >> 1;
            default: quo = mag;
        endcase
        if (r_e1_sum[SUM_W-1]) begin
            mean = H_W'(-$signed({1'b0, quo}));
        end else begin
            mean = H_W'(quo);
        end
    end

    // stage 2: fill the void, blend along the columns
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            hh[i] = r_e2_isv[i] ? r_e2_mean : r_e2_h[i];
        end
        wa   = $signed({1'b0, r_e2_a});
        wna  = $signed({1'b0, ONE_A - r_e2_a});
        wfy  = $signed({1'b0, r_e3_fy});
        wnfy = $signed({1'b0, ONE_A - r_e3_fy});
    end

    // stage 4: truncate toward zero and pick the result
    always_comb begin
        acc_adj = r_e4_acc;
        if (r_e4_acc < 0) begin
            acc_adj = r_e4_acc + ACC_W'((64'd1 << (2 * FRAC_BITS)) - 64'd1);
        end
        blend = acc_adj >>> (2 * FRAC_BITS);
        if (r_e4_voids == 3'd4) begin
            n_alt = i_marker;
        end else if (r_e4_voids >= 3'd2) begin
            n_alt = r_e4_mean;
        end else begin
            n_alt = H_W'(blend);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rd_idx <= r_step;
            r_rd_a   <= i_cmd.a;
            r_rd_fy  <= i_cmd.fy;
            if (r_rd_v) begin
                r_h[r_rd_idx] <= r_rdata;
                if (r_rd_idx == 2'd3) begin
                    r_e0_a  <= r_rd_a;
                    r_e0_fy <= r_rd_fy;
                end
            end
            r_e1_h     <= r_h;
            r_e1_isv   <= isv;
            r_e1_voids <= voids;
            r_e1_sum   <= sum;
            r_e1_a     <= r_e0_a;
            r_e1_fy    <= r_e0_fy;

            r_e2_h     <= r_e1_h;
            r_e2_isv   <= r_e1_isv;
            r_e2_voids <= r_e1_voids;
            r_e2_mean  <= mean;
            r_e2_a     <= r_e1_a;
            r_e2_fy    <= r_e1_fy;

            r_e3_top   <= T_W'(wna * hh[0]) + T_W'(wa * hh[1]);
            r_e3_bot   <= T_W'(wna * hh[2]) + T_W'(wa * hh[3]);
            r_e3_voids <= r_e2_voids;
            r_e3_mean  <= r_e2_mean;
            r_e3_fy    <= r_e2_fy;

            r_e4_acc   <= ACC_W'(wfy * r_e3_top) + ACC_W'(wnfy * r_e3_bot);
            r_e4_voids <= r_e3_voids;
            r_e4_mean  <= r_e3_mean;

            if (r_e4_v) begin
                r_o_alt <= n_alt;
                r_o_vc  <= r_e4_voids;
            end
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.altitude   = r_o_alt;
    assign o_out.void_count = r_o_vc;
endmodule

### rtl/elevation_grid_interpolator.sv
// top level of the elevation grid interpolator
//
// i_in carries load and query transactions. a load writes one byte-swapped
// height word into the tile memory; an index past the tile is dropped. a
// query returns one transaction on o_out with the altitude and the number
// of void neighbours. i_cfg writes the void marker; it is always ready and
// should only be written while no query is in flight.
// a query reads its four neighbours one after another through the single
// port of the tile memory, which also serves every load write, so the back
// end takes no new command until the last read of a query.
// a query passes the front-end registers, the command queue, the four reads
// into the read register, and 5 arithmetic and output stages before it
// reaches o_out.
// reset clears all control state and sets the void marker to -32768; the
// tile memory content is undefined until loaded.
// when o_out is stalled the back end holds, and the front end keeps taking
// items until the four-entry command queue is full.
module elevation_grid_interpolator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    egi_in_if.sink    i_in,
    egi_cfg_if.sink   i_cfg,
    egi_out_if.source o_out
);
    import egi_pkg::*;

    logic signed [15:0] r_void_marker;
    logic               push;
    logic               pop;
    logic               empty;
    logic [CNT_W-1:0]   count;
    t_cmd               push_cmd;
    t_cmd               head_cmd;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_void_marker <= 16'sh8000;
        end else if (i_cfg.valid) begin
            r_void_marker <= i_cfg.data;
        end
    end

    egi_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_fifo_count (count),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    egi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_data  (head_cmd),
        .o_empty (empty),
        .o_count (count)
    );

    egi_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (head_cmd),
        .i_empty  (empty),
        .o_pop    (pop),
        .i_marker (r_void_marker),
        .o_out    (o_out)
    );
endmodule

### rtl/egi_check.sv
// port-level checker for the elevation grid interpolator, bound to the top level
module egi_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_valid,
    input logic        i_cfg_ready,
    input logic [15:0] i_cfg_data,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_altitude,
    input logic [2:0]  i_out_void_count
);
    logic [15:0] r_marker;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker <= 16'h8000;
        end else if (i_cfg_valid && i_cfg_ready) begin
            r_marker <= i_cfg_data;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_altitude))
        else $error("result dropped or changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_void_count <= 3'd4)
        else $error("void count out of range");

    a_all_void: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_void_count == 3'd4 |-> i_out_altitude == r_marker)
        else $error("all-void result is not the void marker");
endmodule

bind elevation_grid_interpolator egi_check u_egi_check (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_cfg_valid      (i_cfg.valid),
    .i_cfg_ready      (i_cfg.ready),
    .i_cfg_data       (i_cfg.data),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_altitude   (o_out.altitude),
    .i_out_void_count (o_out.void_count)
);
